FILE: rtl/elc_pkg.sv
// shared types, codes and character constants of the escaped line classifier
package elc_pkg;

    // operation codes carried in the cmd field
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    // line status codes of a result word
    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_CMD   = 2'd1,
        ST_DATA  = 2'd2,
        ST_BREAK = 2'd3
    } t_status;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_BANG = 8'h21;

    // identify query text, lower case
    localparam logic [7:0] IDN_0 = 8'h2A;
    localparam logic [7:0] IDN_1 = 8'h69;
    localparam logic [7:0] IDN_2 = 8'h64;
    localparam logic [7:0] IDN_3 = 8'h6E;
    localparam logic [7:0] IDN_4 = 8'h3F;

    // ascii upper case to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: rtl/elc_if.sv
// handshake channel interfaces of the escaped line classifier
interface elc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] byte_in;
    logic [7:0] read_index;

    modport source (output valid, output cmd, output byte_in, output read_index, input ready);
    modport sink   (input valid, input cmd, input byte_in, input read_index, output ready);
endinterface

interface elc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] line_status;
    logic [8:0] line_length;
    logic [7:0] read_data;
    logic       idn_request;
    logic       overflow_error;
    logic       buffer_full;

    modport source (output valid, output line_status, output line_length, output read_data,
                    output idn_request, output overflow_error, output buffer_full,
                    input ready);
    modport sink   (input valid, input line_status, input line_length, input read_data,
                    input idn_request, input overflow_error, input buffer_full,
                    output ready);
endinterface

interface elc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/elc_ram.sv
// generic single-port-write, registered-read ram
module elc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the contents before a same-edge write
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/escaped_line_classifier_unit.sv
// top level of the escaped line classifier: parser, line store and result register
// The block takes one word per clock on its input channel: push a host byte, read a
// stored byte, or flush the line store. Every input word gives exactly one result word,
// which appears in the output register in the cycle after acceptance and holds until taken.
// The sustained rate is one word per cycle; input ready is high whenever the output
// register is empty or is being emptied in the same cycle, so a stalled output stalls
// the input. The line store is a synchronous ram written at the fill position on a push
// and read at read_index on a read; its registered read lines up with the output
// register, so a read result carries the byte from the ram output directly. The first
// five stored bytes are also kept in flops so a closing CR can classify the line (command,
// break, identify query or data) in the same cycle. Store contents are not cleared:
// bytes at or above the fill count read as zero. The idn_enable register is written
// through its own channel (always ready); the user writes it only while idle, unchecked.
module escaped_line_classifier_unit #(
    parameter int LINE_DEPTH = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    elc_in_if.sink     i_in,
    elc_out_if.source  o_out,
    elc_cfg_if.sink    i_cfg
);

    // address width of the store and width of the fill count (holds LINE_DEPTH itself)
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    logic [CW-1:0] r_fill,  n_fill;
    logic          r_esc,   n_esc;      // escape pending
    logic          r_pesc,  n_pesc;     // plus escaped at line start
    logic          r_fmark, n_fmark;    // store filled, data released
    logic          r_idn_en;
    logic [7:0]    r_pre [5];           // shadow of the first five stored bytes

    // output register
    logic          r_out_valid;
    logic [1:0]    r_status,  n_status;
    logic [8:0]    r_len;
    logic          r_idn,     n_idn;
    logic          r_ovf,     n_ovf;
    logic          r_full,    n_full;
    logic          r_rd_ok,   n_rd_ok;

    // store access
    logic          w_put;
    logic [7:0]    w_put_byte;
    logic          w_accept;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_ram_q;

    // widened views for compares and truncation
    logic [AW+7:0] w_ridx_wide;
    logic [CW+7:0] w_ridx_cmp;
    logic [CW+7:0] w_fill_cmp;
    logic [CW+8:0] w_len_wide;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idn_en <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_idn_en <= i_cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // line store ram
    // ------------------------------------------------------------------
    assign w_ridx_wide = {{AW{1'b0}}, i_in.read_index};
    assign w_raddr     = w_ridx_wide[AW-1:0];
    assign w_re        = w_accept && (i_in.cmd == elc_pkg::CMD_READ);

    elc_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_put),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (w_put_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // read is in range only below the fill count (fill never passes the depth)
    assign w_ridx_cmp = {{CW{1'b0}}, i_in.read_index};
    assign w_fill_cmp = {8'd0, r_fill};

    // ------------------------------------------------------------------
    // parser and classifier
    // ------------------------------------------------------------------
    logic w_is_cmd;
    logic w_is_idn;
    logic w_starts_cmd;
    logic w_full_now;

    always_comb begin
        // command line: more than two bytes, two plus signs, neither of them escaped
        w_starts_cmd = (r_fill >= CW'(2)) && (r_pre[0] == elc_pkg::CH_PLUS)
                       && (r_pre[1] == elc_pkg::CH_PLUS);
        w_is_cmd     = (r_fill > CW'(2)) && w_starts_cmd && !r_pesc;
        w_is_idn     = (r_fill >= CW'(5))
                       && (r_pre[0] == elc_pkg::IDN_0)
                       && (elc_pkg::to_lower(r_pre[1]) == elc_pkg::IDN_1)
                       && (elc_pkg::to_lower(r_pre[2]) == elc_pkg::IDN_2)
                       && (elc_pkg::to_lower(r_pre[3]) == elc_pkg::IDN_3)
                       && (elc_pkg::to_lower(r_pre[4]) == elc_pkg::IDN_4);
    end

    always_comb begin
        n_fill     = r_fill;
        n_esc      = r_esc;
        n_pesc     = r_pesc;
        n_fmark    = r_fmark;
        n_status   = elc_pkg::ST_NONE;
        n_idn      = 1'b0;
        n_ovf      = 1'b0;
        n_full     = 1'b0;
        n_rd_ok    = 1'b0;
        w_put      = 1'b0;
        w_put_byte = i_in.byte_in;
        w_full_now = 1'b0;

        case (i_in.cmd)
            elc_pkg::CMD_READ: begin
                n_rd_ok = w_ridx_cmp < w_fill_cmp;
            end
            elc_pkg::CMD_FLUSH: begin
                n_fill  = '0;
                n_fmark = 1'b0;
            end
            elc_pkg::CMD_PUSH: begin
                // a byte into a full store is dropped
                if (r_fill < CW'(LINE_DEPTH)) begin
                    case (i_in.byte_in)
                        elc_pkg::CH_LF: begin
                            // line feed is ignored
                        end
                        elc_pkg::CH_CR: begin
                            if (r_esc) begin
                                w_put = 1'b1;
                                n_esc = 1'b0;
                            end else if (r_fill == '0) begin
                                // blank line
                                n_fill  = '0;
                                n_fmark = 1'b0;
                            end else begin
                                if (w_is_cmd) begin
                                    if (r_pre[2] == elc_pkg::CH_BANG) begin
                                        n_status = elc_pkg::ST_BREAK;
                                        n_fill   = '0;
                                        n_fmark  = 1'b0;
                                    end else begin
                                        n_status = elc_pkg::ST_CMD;
                                    end
                                end else if (r_idn_en && w_is_idn) begin
                                    n_idn   = 1'b1;
                                    n_fill  = '0;
                                    n_fmark = 1'b0;
                                end else begin
                                    n_status = elc_pkg::ST_DATA;
                                end
                                n_pesc = 1'b0;
                            end
                        end
                        elc_pkg::CH_ESC: begin
                            if (r_esc) begin
                                w_put = 1'b1;
                                n_esc = 1'b0;
                            end else begin
                                n_esc = 1'b1;
                            end
                        end
                        elc_pkg::CH_PLUS: begin
                            if (r_esc) begin
                                n_esc = 1'b0;
                                if (r_fill < CW'(2)) begin
                                    n_pesc = 1'b1;
                                end
                            end
                            w_put = 1'b1;
                        end
                        default: begin
                            w_put = 1'b1;
                            n_esc = 1'b0;
                        end
                    endcase
                    if (w_put) begin
                        n_fill = r_fill + CW'(1);
                    end
                end

                // store full after this byte: drop a command, release data
                // (the first two bytes lie below the fill position here)
                w_full_now = (n_fill == CW'(LINE_DEPTH));
                if (w_full_now) begin
                    if (w_starts_cmd && (n_status == elc_pkg::ST_NONE)) begin
                        n_ovf   = 1'b1;
                        n_fill  = '0;
                        n_fmark = 1'b0;
                    end else begin
                        n_fmark  = 1'b1;
                        n_status = elc_pkg::ST_DATA;
                    end
                end
                n_full = (n_status == elc_pkg::ST_DATA) && n_fmark;
            end
            default: begin
                // unused command: no change
            end
        endcase
    end

    assign w_len_wide = {9'd0, n_fill};

    // ------------------------------------------------------------------
    // state update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_esc   <= 1'b0;
            r_pesc  <= 1'b0;
            r_fmark <= 1'b0;
        end else if (w_accept) begin
            r_fill  <= n_fill;
            r_esc   <= n_esc;
            r_pesc  <= n_pesc;
            r_fmark <= n_fmark;
        end
    end

    // prefix shadow, written alongside the ram for the first five positions
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 5; k++) begin
            if (w_accept && w_put && (r_fill == CW'(k))) begin
                r_pre[k] <= w_put_byte;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_len    <= w_len_wide[8:0];
            r_idn    <= n_idn;
            r_ovf    <= n_ovf;
            r_full   <= n_full;
            r_rd_ok  <= n_rd_ok;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.line_status    = r_status;
    assign o_out.line_length    = r_len;
    assign o_out.read_data      = r_rd_ok ? w_ram_q : 8'd0;
    assign o_out.idn_request    = r_idn;
    assign o_out.overflow_error = r_ovf;
    assign o_out.buffer_full    = r_full;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(LINE_DEPTH))
        else $error("fill count beyond store depth");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.cmd == elc_pkg::CMD_FLUSH)) |=> (r_fill == '0))
        else $error("flush left bytes in the store");

    a_ovf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |-> ((r_len == 9'd0) && (r_status == elc_pkg::ST_NONE)))
        else $error("overflow result with a non-empty store");

    a_full_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_full) |-> (r_status == elc_pkg::ST_DATA))
        else $error("full mark without a data line");

endmodule
